/* hw/rtl/huffman_tree_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// Same-cycle implication, masked during reset
`define HTD_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htd: same-cycle check failed");

// Next-cycle implication, masked during reset
`define HTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htd: next-cycle check failed");

`endif

/* hw/rtl/htd_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Opcodes, field widths and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package htd_pkg;

  // Field widths
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 32;
  localparam int CODE_IDX_W = 5;
  localparam int BYTE_BITS  = 8;
  localparam int BIT_W      = 3;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  // Register index (paddr bits above the byte offset)
  localparam logic [PADDR_W-3:0] REG_SYMBOL_COUNT = 1'b0;

  // Configuration write toward the datapath
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } cfg_wr_t;

  // Controller commands
  typedef struct packed {
    logic cap;
    logic clr;
    logic ld_rd;
    logic ld_adv;
    logic ld_new;
    logic ld_store;
    logic ld_fail;
    logic dc_rd_walk;
    logic dc_rd_link;
    logic dc_descend;
    logic dc_leaf;
    logic dc_miss;
    logic flush;
    logic fin;
  } dp_cmd_t;

  // Datapath status
  typedef struct packed {
    logic done_flag;
    logic ld_end;
    logic ld_link_zero;
    logic store_full;
    logic dc_link_zero;
    logic is_leaf;
    logic last_bit;
    logic count_hit;
    logic slot_free;
    logic staged_valid;
  } dp_status_t;

endpackage

/* hw/rtl/htd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/htd_cfg.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder register port
// APB-style access to the symbol count register.
// ----------------------------------------------------------------------------
module htd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [htd_pkg::PADDR_W-1:0] paddr,
  input  logic [htd_pkg::DATA_W-1:0]  pwdata,
  output logic [htd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output htd_pkg::cfg_wr_t            cfg_wr
);
  import htd_pkg::*;

  logic [DATA_W-1:0] symbol_count;
  logic              hit;
  logic              wr_en;

  // Decode register select and write strobe
  assign hit    = (paddr[PADDR_W-1:2] == REG_SYMBOL_COUNT);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  // Hold the symbol count
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= DATA_W'(1);
    end else if (wr_en) begin
      symbol_count <= pwdata;
    end
  end

  // Read back
  assign prdata = hit ? symbol_count : '0;

  // Forward the write to the datapath
  assign cfg_wr.valid = wr_en;
  assign cfg_wr.value = pwdata;

endmodule

/* hw/rtl/htd_datapath.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder datapath
// Node store, load and walk pointers, symbol counter and result register.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_macros.svh"

module htd_datapath #(
  parameter int NODES        = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  htd_pkg::dp_cmd_t           cmd,
  output htd_pkg::dp_status_t        status,
  input  htd_pkg::cfg_wr_t           cfg_wr,
  input  logic [htd_pkg::SYM_W-1:0]  entry_symbol,
  input  logic [htd_pkg::LEN_W-1:0]  code_length,
  input  logic [htd_pkg::CODE_W-1:0] code_bits,
  input  logic [htd_pkg::BYTE_BITS-1:0] encoded_byte,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [htd_pkg::SYM_W-1:0]  out_symbol,
  output logic                       out_has,
  output logic                       out_last,
  output logic                       out_done,
  output logic                       out_err
);
  import htd_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int EW = 2 * AW + SYM_W;
  localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_CODE_LEN);

  // Captured item
  logic [SYM_W-1:0]     ld_sym;
  logic [LEN_W-1:0]     ld_len;
  logic [CODE_W-1:0]    ld_bits;
  logic [BYTE_BITS-1:0] dc_byte;

  // Load walk
  logic [AW-1:0]    cur;
  logic             ld_fresh;
  logic [LEN_W-1:0] ld_idx;
  logic [CW-1:0]    node_count;
  logic             root_clean;

  // Decode walk
  logic [AW-1:0]    walk;
  logic [AW-1:0]    child;
  logic [BIT_W-1:0] bit_idx;
  logic [DATA_W-1:0] symbols_left;
  logic             done_flag;

  // Pending result
  logic             staged_valid;
  logic             staged_err;
  logic [SYM_W-1:0] staged_sym;

  // Node store access
  logic          mask_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [EW-1:0] entry;
  logic [AW-1:0] e_left;
  logic [AW-1:0] e_right;
  logic [SYM_W-1:0] e_sym;

  logic          ld_bit;
  logic [AW-1:0] ld_link;
  logic          dc_bit;
  logic [AW-1:0] dc_link;
  logic [AW-1:0] new_link;
  logic          store_full;
  logic          slot_free;
  logic [LEN_W-1:0] eff_len;

  htd_ram #(.WIDTH(EW), .DEPTH(NODES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Unpack the node read; fresh nodes and a cleared root read as empty
  assign entry   = mask_q ? '0 : rdata;
  assign e_left  = entry[AW-1:0];
  assign e_right = entry[2*AW-1:AW];
  assign e_sym   = entry[EW-1:2*AW];

  // Branch selection
  assign ld_bit   = (ld_idx < LEN_W'(CODE_W)) ? ld_bits[ld_idx[CODE_IDX_W-1:0]] : 1'b0;
  assign ld_link  = ld_bit ? e_right : e_left;
  assign dc_bit   = dc_byte[bit_idx];
  assign dc_link  = dc_bit ? e_right : e_left;
  assign new_link = node_count[AW-1:0];

  assign store_full = (node_count >= CW'(NODES));
  assign slot_free  = !out_valid || out_ready;
  assign eff_len    = ({1'b0, code_length} > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : code_length;

  // Store write: link update, symbol store, or rewrite on overflow
  assign we    = cmd.ld_new || cmd.ld_store || cmd.ld_fail;
  assign waddr = cur;
  always_comb begin
    priority if (cmd.ld_new) begin
      wdata = ld_bit ? {e_sym, new_link, e_left} : {e_sym, e_right, new_link};
    end else if (cmd.ld_store) begin
      wdata = {ld_sym, e_right, e_left};
    end else begin
      wdata = entry;
    end
  end

  // Store read address
  assign re = cmd.ld_rd || cmd.dc_rd_walk || cmd.dc_rd_link;
  always_comb begin
    priority if (cmd.ld_rd) begin
      raddr = cur;
    end else if (cmd.dc_rd_walk) begin
      raddr = walk;
    end else begin
      raddr = dc_link;
    end
  end

  // Track whether the next read data must be treated as an empty node
  always_ff @(posedge clk) begin
    if (cmd.ld_rd) begin
      mask_q <= ld_fresh || ((cur == '0) && root_clean);
    end else if (cmd.dc_rd_walk) begin
      mask_q <= (walk == '0) && root_clean;
    end else if (cmd.dc_rd_link) begin
      mask_q <= 1'b0;
    end
  end

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ld_sym  <= entry_symbol;
      ld_len  <= eff_len;
      ld_bits <= code_bits;
      dc_byte <= encoded_byte;
    end
  end

  // Load pointer and bit index
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur      <= '0;
      ld_fresh <= 1'b0;
      ld_idx   <= '0;
    end else if (cmd.ld_adv) begin
      cur      <= ld_link;
      ld_fresh <= 1'b0;
      ld_idx   <= ld_idx + LEN_W'(1);
    end else if (cmd.ld_new) begin
      cur      <= new_link;
      ld_fresh <= 1'b1;
      ld_idx   <= ld_idx + LEN_W'(1);
    end
  end

  // Node allocation and root state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CW'(1);
      root_clean <= 1'b1;
    end else if (cmd.clr) begin
      node_count <= CW'(1);
      root_clean <= 1'b1;
    end else begin
      if (cmd.ld_new) begin
        node_count <= node_count + CW'(1);
      end
      if (we && (waddr == '0)) begin
        root_clean <= 1'b0;
      end
    end
  end

  // Decode walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.clr || cmd.dc_leaf || cmd.dc_miss) begin
      walk <= '0;
    end else if (cmd.dc_descend) begin
      walk <= child;
    end
  end

  // Child pointer and bit index
  always_ff @(posedge clk) begin
    if (cmd.dc_rd_link) begin
      child <= dc_link;
    end
    if (cmd.cap) begin
      bit_idx <= '0;
    end else if (cmd.dc_leaf || cmd.dc_descend) begin
      bit_idx <= bit_idx + BIT_W'(1);
    end
  end

  // Symbol countdown and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_left <= DATA_W'(1);
      done_flag    <= 1'b0;
    end else if (cfg_wr.valid) begin
      symbols_left <= cfg_wr.value;
      done_flag    <= (cfg_wr.value == '0);
    end else if (cmd.dc_leaf) begin
      symbols_left <= symbols_left - DATA_W'(1);
      if (symbols_left == DATA_W'(1)) begin
        done_flag <= 1'b1;
      end
    end
  end

  // Pending result: the latest symbol or an error, held until its last bit is known
  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
    end else if (cmd.cap) begin
      staged_valid <= 1'b0;
    end else if (cmd.dc_leaf) begin
      staged_valid <= 1'b1;
    end else if (cmd.dc_miss || cmd.ld_fail) begin
      staged_valid <= 1'b1;
    end else if (cmd.flush || cmd.fin) begin
      staged_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dc_leaf) begin
      staged_err <= 1'b0;
      staged_sym <= e_sym;
    end else if (cmd.dc_miss || cmd.ld_fail) begin
      staged_err <= 1'b1;
      staged_sym <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush || cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush || cmd.fin) begin
      out_has    <= staged_valid && !staged_err;
      out_symbol <= (staged_valid && !staged_err) ? staged_sym : '0;
      out_err    <= staged_valid && staged_err;
      out_done   <= done_flag;
      out_last   <= cmd.fin;
    end
  end

  // Status toward the controller
  assign status.done_flag    = done_flag;
  assign status.ld_end       = (ld_idx == ld_len);
  assign status.ld_link_zero = (ld_link == '0);
  assign status.store_full   = store_full;
  assign status.dc_link_zero = (dc_link == '0);
  assign status.is_leaf      = (e_left == '0) && (e_right == '0);
  assign status.last_bit     = (bit_idx == BIT_W'(BYTE_BITS - 1));
  assign status.count_hit    = (symbols_left == DATA_W'(1));
  assign status.slot_free    = slot_free;
  assign status.staged_valid = staged_valid;

  // Checks
  `HTD_ASSERT_IMPL(a_emit_slot, clk, rst, cmd.flush || cmd.fin, slot_free)
  `HTD_ASSERT_IMPL(a_flush_staged, clk, rst, cmd.flush, staged_valid)
  `HTD_ASSERT_IMPL(a_alloc_room, clk, rst, cmd.ld_new, !store_full)
  `HTD_ASSERT_NEXT(a_fin_shows, clk, rst, cmd.fin, out_valid && out_last)
  `HTD_ASSERT_IMPL(a_count_range, clk, rst, 1'b1,
                   (node_count != '0) && (node_count <= CW'(NODES)))

endmodule

/* hw/rtl/htd_ctrl.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder controller
// Sequences clear, code load and byte decode over the datapath.
// ----------------------------------------------------------------------------
module htd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  htd_pkg::dp_status_t status,
  output htd_pkg::dp_cmd_t    cmd
);
  import htd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LD_RD    = 3'd1;
  localparam logic [2:0] S_LD_EX    = 3'd2;
  localparam logic [2:0] S_DC_RD    = 3'd3;
  localparam logic [2:0] S_DC_NODE  = 3'd4;
  localparam logic [2:0] S_DC_CHILD = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       emit_block;

  assign in_ready   = (state == S_IDLE);
  assign emit_block = status.staged_valid && !status.slot_free;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          unique case (opcode)
            OP_CLEAR: begin
              cmd.clr    = 1'b1;
              state_next = S_FIN;
            end
            OP_LOAD: begin
              state_next = S_LD_RD;
            end
            OP_DECODE: begin
              state_next = status.done_flag ? S_FIN : S_DC_RD;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_LD_RD: begin
        cmd.ld_rd  = 1'b1;
        state_next = S_LD_EX;
      end
      S_LD_EX: begin
        priority if (status.ld_end) begin
          cmd.ld_store = 1'b1;
          state_next   = S_FIN;
        end else if (!status.ld_link_zero) begin
          cmd.ld_adv = 1'b1;
          state_next = S_LD_RD;
        end else if (status.store_full) begin
          cmd.ld_fail = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.ld_new = 1'b1;
          state_next = S_LD_RD;
        end
      end
      S_DC_RD: begin
        cmd.dc_rd_walk = 1'b1;
        state_next     = S_DC_NODE;
      end
      S_DC_NODE: begin
        if (status.dc_link_zero) begin
          // Missing child: flush any pending symbol, then report the error
          if (!emit_block) begin
            cmd.flush   = status.staged_valid;
            cmd.dc_miss = 1'b1;
            state_next  = S_FIN;
          end
        end else begin
          cmd.dc_rd_link = 1'b1;
          state_next     = S_DC_CHILD;
        end
      end
      S_DC_CHILD: begin
        if (status.is_leaf) begin
          // Leaf: push out the previous symbol, hold this one as pending
          if (!emit_block) begin
            cmd.flush   = status.staged_valid;
            cmd.dc_leaf = 1'b1;
            state_next  = (status.count_hit || status.last_bit) ? S_FIN : S_DC_RD;
          end
        end else begin
          cmd.dc_descend = 1'b1;
          state_next     = status.last_bit ? S_FIN : S_DC_NODE;
        end
      end
      S_FIN: begin
        if (status.slot_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/huffman_tree_decoder.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Bit-serial Huffman decoder that builds and walks a code tree in a node RAM.
//
//   Channel   Dir   Transfer                     Contents
//   s_*       in    s_tvalid & s_tready          one command: clear, load, decode
//   m_*       out   m_tvalid & m_tready          one result, tlast on the final one
//   APB       in    psel & penable & pwrite      symbol count register at 0x0
//
// One item is processed at a time; the next is taken once its final result
// transaction has been handed to the output register.
// Load and decode walk the tree one node read at a time through the single read
// port of the node RAM, whose read data is registered.
// A stalled output holds the walk until the result register frees up.
// Reset needs no clearing pass: nodes are written when allocated.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int NODES        = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // Command stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [55:0]                 s_tdata,  // entry_symbol[7:0], code_length[13:8],
                                                // code_bits[45:14], encoded_byte[53:46]
  input  logic [1:0]                  s_tuser,  // opcode[1:0]
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,  // symbol[7:0], done_res[8]
  output logic [1:0]                  m_tuser,  // has_symbol[0], error[1]
  output logic                        m_tlast,
  // Register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [htd_pkg::PADDR_W-1:0] paddr,
  input  logic [htd_pkg::DATA_W-1:0]  pwdata,
  output logic [htd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import htd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  cfg_wr_t    cfg_wr;

  logic [SYM_W-1:0] out_symbol;
  logic             out_has;
  logic             out_done;
  logic             out_err;

  htd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_wr  (cfg_wr)
  );

  htd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .opcode   (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  htd_datapath #(
    .NODES        (NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .entry_symbol (s_tdata[7:0]),
    .code_length  (s_tdata[13:8]),
    .code_bits    (s_tdata[45:14]),
    .encoded_byte (s_tdata[53:46]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_symbol   (out_symbol),
    .out_has      (out_has),
    .out_last     (m_tlast),
    .out_done     (out_done),
    .out_err      (out_err)
  );

  // Pack the result fields
  assign m_tdata = {7'b0, out_done, out_symbol};
  assign m_tuser = {out_err, out_has};

endmodule

/* tb/huffman_tree_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder testbench
// Drives clear, load and decode commands into the command stream and checks
// every result transaction against a cycle-free model of the code tree. A
// short directed table covers reset, empty and full codes, long codes, missing
// children and the done condition. Random phases follow: complete and broken
// code tables with random byte streams, store overflow and plain noise.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htd_pkg::*;

  localparam int NODE_CNT    = 512;
  localparam int MAX_LEN     = 32;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_WAIT    = 64;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 60;
  localparam int ROWS        = 23;

  localparam logic [1:0]         OP_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_SYMBOL_COUNT, 2'b00};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             has_sym;
    logic             last;
    logic             done;
    logic             err;
  } res_t;

  typedef struct packed {
    logic              cfg_en;
    logic [DATA_W-1:0] cfg_val;
    logic [1:0]        op;
    logic [SYM_W-1:0]  esym;
    logic [LEN_W-1:0]  clen;
    logic [CODE_W-1:0] cbits;
    logic [7:0]        ebyte;
    logic              fixed;
    res_t              fixed_res;
  } cmd_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_SLOW} rx_mode_t;

  // Results that can be read straight off the command
  localparam res_t R_NONE  = '0;
  localparam res_t R_EMPTY = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam res_t R_MISS  = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam res_t R_DONE  = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};

  // Directed rows: register write, command, typed result where obvious
  localparam cmd_t DIRECTED [ROWS] = '{
    // decode on the bare root hits a missing child
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b1, R_MISS},
    '{1'b0, 32'd0, OP_UNUSED, 8'hFF, 6'd63, 32'hFFFFFFFF, 8'hFF, 1'b1, R_EMPTY},
    '{1'b0, 32'd0, OP_CLEAR, 8'h00, 6'd0, 32'h0, 8'h00, 1'b1, R_EMPTY},
    // empty code lands on the root, then a two-leaf tree
    '{1'b0, 32'd0, OP_LOAD, 8'h00, 6'd0, 32'h0, 8'h00, 1'b1, R_EMPTY},
    '{1'b0, 32'd0, OP_LOAD, 8'hFF, 6'd1, 32'h0, 8'h00, 1'b1, R_EMPTY},
    '{1'b0, 32'd0, OP_LOAD, 8'hA5, 6'd1, 32'h1, 8'h00, 1'b1, R_EMPTY},
    // count of one from reset: first bit finishes, the rest is dropped
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h55, 1'b1, R_DONE},
    // largest count: eight symbols per byte
    '{1'b1, 32'hFFFFFFFF, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h5A, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_CLEAR, 8'h00, 6'd0, 32'h0, 8'h00, 1'b1, R_EMPTY},
    // longest codes: all right, and an over-long one cut to all left
    '{1'b0, 32'd0, OP_LOAD, 8'h3C, 6'd32, 32'hFFFFFFFF, 8'h00, 1'b1, R_EMPTY},
    '{1'b0, 32'd0, OP_LOAD, 8'hC3, 6'd63, 32'h0, 8'h00, 1'b1, R_EMPTY},
    // walk spans four bytes before the leaf
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1'b0, R_NONE},
    // missing child on the second bit of a byte
    '{1'b0, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h01, 1'b0, R_NONE},
    '{1'b0, 32'd0, OP_LOAD, 8'h81, 6'd33, 32'hAAAAAAAA, 8'h00, 1'b0, R_NONE},
    // zero count is done at once
    '{1'b1, 32'd0, OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h00, 1'b1, R_DONE},
    '{1'b0, 32'd0, OP_LOAD, 8'h11, 6'd2, 32'h2, 8'h00, 1'b1, R_DONE},
    '{1'b1, 32'd2, OP_CLEAR, 8'h00, 6'd0, 32'h0, 8'h00, 1'b1, R_EMPTY}
  };

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [55:0]         s_tdata;  // entry_symbol[7:0], code_length[13:8],
                                 // code_bits[45:14], encoded_byte[53:46]
  logic [1:0]          s_tuser;  // opcode[1:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;  // symbol[7:0], done_res[8]
  logic [1:0]          m_tuser;  // has_symbol[0], error[1]
  logic                m_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Tree model state
  int unsigned       tree_left [NODE_CNT];
  int unsigned       tree_right [NODE_CNT];
  logic [SYM_W-1:0]  tree_sym [NODE_CNT];
  int unsigned       node_used;
  int unsigned       walk_pos;
  logic [DATA_W-1:0] symbols_to_go;
  bit                count_done;

  res_t        pending_results[$];
  cmd_t        offered_cmd;
  int          cmds_taken;
  int          cmds_sent;
  int          err_cnt;
  int          burst_left;
  int unsigned cycle_cnt;

  // Code table under construction
  logic [CODE_W-1:0] code_path [32];
  int                leaf_depth [32];
  int                code_order [32];
  int                leaf_cnt;

  huffman_tree_decoder #(
    .NODES        (NODE_CNT),
    .MAX_CODE_LEN (MAX_LEN)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tree model
  // ---------------------------------------------------------------------------
  function automatic void clear_tree();
    for (int i = 0; i < NODE_CNT; i++) begin
      tree_left[i]  = 0;
      tree_right[i] = 0;
      tree_sym[i]   = '0;
    end
    node_used = 1;
    walk_pos  = 0;
  endfunction

  function automatic void set_count(input logic [DATA_W-1:0] val);
    symbols_to_go = val;
    count_done    = (val == 0);
  endfunction

  function automatic res_t make_res(input logic [SYM_W-1:0] s, input logic has,
                                    input logic lst, input logic e);
    res_t r;
    r.symbol  = s;
    r.has_sym = has;
    r.last    = lst;
    r.done    = count_done;
    r.err     = e;
    return r;
  endfunction

  // Follow the code from the root, growing nodes; returns 1 when the store runs out
  function automatic bit grow_path(input logic [SYM_W-1:0] s, input logic [LEN_W-1:0] len,
                                   input logic [CODE_W-1:0] bits);
    int unsigned nd;
    int unsigned lim;
    int unsigned link;
    bit          go_right;
    nd  = 0;
    lim = (len > MAX_LEN) ? MAX_LEN : len;
    for (int i = 0; i < lim; i++) begin
      go_right = (i < CODE_W) ? bits[i] : 1'b0;
      link = go_right ? tree_right[nd] : tree_left[nd];
      if (link == 0) begin
        if (node_used >= NODE_CNT) return 1'b1;
        link = node_used;
        node_used++;
        if (go_right) tree_right[nd] = link;
        else tree_left[nd] = link;
      end
      nd = link;
    end
    tree_sym[nd] = s;
    return 1'b0;
  endfunction

  // Work out the results of one accepted command and queue them
  function automatic void predict_results(input cmd_t c);
    res_t        out_q[$];
    int unsigned nxt;
    bit          stop;
    bit          overflow;
    stop = 1'b0;
    if (c.op == OP_CLEAR) begin
      clear_tree();
      out_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b0));
    end else if (c.op == OP_LOAD) begin
      overflow = grow_path(c.esym, c.clen, c.cbits);
      out_q.push_back(make_res(8'h00, 1'b0, 1'b1, overflow));
    end else if (c.op != OP_DECODE || count_done) begin
      out_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b0));
    end else begin
      for (int b = 0; b < BYTE_BITS && !stop; b++) begin
        nxt = c.ebyte[b] ? tree_right[walk_pos] : tree_left[walk_pos];
        if (nxt == 0) begin
          walk_pos = 0;
          out_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b1));
          stop = 1'b1;
        end else if (tree_left[nxt] == 0 && tree_right[nxt] == 0) begin
          walk_pos = 0;
          symbols_to_go--;
          if (symbols_to_go == 0) begin
            count_done = 1'b1;
            out_q.push_back(make_res(tree_sym[nxt], 1'b1, 1'b1, 1'b0));
            stop = 1'b1;
          end else begin
            out_q.push_back(make_res(tree_sym[nxt], 1'b1, 1'b0, 1'b0));
          end
        end else begin
          walk_pos = nxt;
        end
      end
      if (!stop) begin
        if (out_q.size() == 0) out_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b0));
        else out_q[out_q.size()-1].last = 1'b1;
      end
    end
    // Typed rows replace the model's answer, but the model state still advances
    if (c.fixed) pending_results.push_back(c.fixed_res);
    else foreach (out_q[i]) pending_results.push_back(out_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: queue expectations on command transactions, check result ones
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    res_t got;
    res_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_results(offered_cmd);
        cmds_taken++;
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[8], m_tuser[1]};
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected result sym=%02h has=%0b last=%0b done=%0b err=%0b",
                     $time, got.symbol, got.has_sym, got.last, got.done, got.err);
        end else begin
          want = pending_results.pop_front();
          if (got.symbol !== want.symbol) begin
            err_cnt++;
            if (err_cnt < MAX_REPORTS)
              $display("%0t: symbol expected %02h got %02h", $time, want.symbol, got.symbol);
          end
          if (got.has_sym !== want.has_sym) begin
            err_cnt++;
            if (err_cnt < MAX_REPORTS)
              $display("%0t: has_symbol expected %0b got %0b", $time, want.has_sym,
                       got.has_sym);
          end
          if (got.last !== want.last) begin
            err_cnt++;
            if (err_cnt < MAX_REPORTS)
              $display("%0t: tlast expected %0b got %0b", $time, want.last, got.last);
          end
          if (got.done !== want.done) begin
            err_cnt++;
            if (err_cnt < MAX_REPORTS)
              $display("%0t: done_res expected %0b got %0b", $time, want.done, got.done);
          end
          if (got.err !== want.err) begin
            err_cnt++;
            if (err_cnt < MAX_REPORTS)
              $display("%0t: error expected %0b got %0b", $time, want.err, got.err);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: shifting stall patterns plus one long hold-off under load
  // ---------------------------------------------------------------------------
  initial begin : rx
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       comb_len;
    int       tick;
    bit       hold_done;
    m_tready  = 1'b0;
    mode      = RX_OPEN;
    seg_left  = 0;
    hold_left = 0;
    comb_len  = 2;
    tick      = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && cmds_taken >= HOLD_AT && s_tvalid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 160);
          comb_len = $urandom_range(2, 5);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_OPEN: m_tready = 1'b1;
          RX_COIN: m_tready = $urandom_range(0, 1);
          RX_COMB: m_tready = (tick % comb_len) == 0;
          default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register port
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t c);
    @(negedge clk);
    // Drop valid for a gap between bursts
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    offered_cmd = c;
    s_tdata     = {2'b00, c.ebyte, c.cbits, c.clen, c.esym};
    s_tuser     = c.op;
    s_tvalid    = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c.op != OP_UNUSED) cmds_sent++;
  endtask

  // Hold off until every queued result has been taken
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write the symbol count, then read it back
  task automatic write_count(input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = COUNT_ADDR;
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    set_count(val);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) begin
      err_cnt++;
      $display("%0t: symbol_count read expected %08h got %08h", $time, val, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic cmd_t plain_cmd(input logic [1:0] op, input logic [SYM_W-1:0] s,
                                     input logic [LEN_W-1:0] len,
                                     input logic [CODE_W-1:0] bits,
                                     input logic [7:0] byte_val);
    cmd_t c;
    c       = '0;
    c.op    = op;
    c.esym  = s;
    c.clen  = len;
    c.cbits = bits;
    c.ebyte = byte_val;
    return c;
  endfunction

  function automatic cmd_t noise_cmd();
    return plain_cmd(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom_range(0, 63)),
                     $urandom, 8'($urandom));
  endfunction

  function automatic cmd_t decode_cmd();
    return plain_cmd(OP_DECODE, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
  endfunction

  function automatic logic [DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFFFFFF;
      1:       return $urandom;
      2:       return 32'd0;
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  // Build a complete prefix code by splitting leaves at random
  task automatic build_code(input int want, input int max_depth);
    int j;
    int tries;
    int tmp;
    int k;
    leaf_cnt      = 1;
    code_path[0]  = '0;
    leaf_depth[0] = 0;
    tries         = 0;
    while (leaf_cnt < want && tries < 200) begin
      j = $urandom_range(0, leaf_cnt - 1);
      if (leaf_depth[j] < max_depth) begin
        code_path[leaf_cnt]  = code_path[j] | (32'd1 << leaf_depth[j]);
        leaf_depth[leaf_cnt] = leaf_depth[j] + 1;
        leaf_depth[j]++;
        leaf_cnt++;
      end
      tries++;
    end
    // Shuffle the load order
    for (int i = 0; i < leaf_cnt; i++) code_order[i] = i;
    for (int i = leaf_cnt - 1; i > 0; i--) begin
      k             = $urandom_range(0, i);
      tmp           = code_order[i];
      code_order[i] = code_order[k];
      code_order[k] = tmp;
    end
  endtask

  // Clear, load a code table (sometimes with a hole), then stream bytes
  task automatic code_phase();
    int skip;
    int depth;
    int n_bytes;
    int idx;
    depth = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(2, 8);
    build_code($urandom_range(2, 16), depth);
    skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, leaf_cnt - 1) : -1;
    send_cmd(plain_cmd(OP_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom)));
    for (int i = 0; i < leaf_cnt; i++) begin
      idx = code_order[i];
      if (idx != skip)
        send_cmd(plain_cmd(OP_LOAD, 8'($urandom), 6'(leaf_depth[idx]),
                           code_path[idx] | ($urandom << leaf_depth[idx]), 8'($urandom)));
      if ($urandom_range(0, 19) == 0) send_cmd(noise_cmd());
    end
    n_bytes = $urandom_range(8, 30);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 24) == 0) send_cmd(noise_cmd());
      else send_cmd(decode_cmd());
    end
  endtask

  // Load 22 long random codes into a cleared store to push loads toward overflow
  task automatic fill_phase();
    send_cmd(plain_cmd(OP_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom)));
    for (int i = 0; i < 22; i++)
      send_cmd(plain_cmd(OP_LOAD, 8'($urandom), 6'($urandom_range(20, 63)), $urandom,
                         8'($urandom)));
    for (int i = 0; i < 6; i++) send_cmd(decode_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : seq
    int pick;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    offered_cmd = '0;
    cmds_taken = 0;
    cmds_sent  = 0;
    err_cnt    = 0;
    burst_left = 0;
    cycle_cnt  = 0;
    clear_tree();
    set_count(32'd1);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int r = 0; r < ROWS; r++) begin
      if (DIRECTED[r].cfg_en) begin
        wait_idle();
        write_count(DIRECTED[r].cfg_val);
      end
      send_cmd(DIRECTED[r]);
    end

    // Random phases, each opened with a new symbol count
    while (cmds_sent < ITEM_TARGET) begin
      wait_idle();
      write_count(pick_count());
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        code_phase();
      end else if (pick < 17) begin
        fill_phase();
      end else begin
        for (int i = 0; i < 15; i++) send_cmd(noise_cmd());
      end
    end

    // Drain, then let any stray result show up
    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
